// ===== rtl/ssb_pkg.sv =====
package ssb_pkg;

   // Pool and counter sizing
   localparam int MAX_SERVERS = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = $clog2(MAX_SERVERS);
   localparam int POOL_W      = $clog2(MAX_SERVERS + 1);
   localparam int SCOUNT_W    = 5;
   localparam int HASH_W      = 32;
   localparam int HSTEP_W     = $clog2(HASH_W);
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   // Item kinds
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_HEALTH  = 2'd2;

   // Selection policies
   localparam logic [1:0] MODE_RR   = 2'd0;
   localparam logic [1:0] MODE_LC   = 2'd1;
   localparam logic [1:0] MODE_HASH = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_FORWARDED  = 2'd0;
   localparam logic [1:0] STATUS_NO_SERVERS = 2'd1;
   localparam logic [1:0] STATUS_DEAD       = 2'd2;
   localparam logic [1:0] STATUS_ACK        = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        server_index;
      logic              alive_flag;
      logic [HASH_W-1:0] client_hash;
   } req_type;

   typedef struct packed {
      logic [3:0] chosen_server;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [POOL_W-1:0] count;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] dividend;
      logic [POOL_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/ssb_ram.sv =====
module ssb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ssb_divider.sv =====
module ssb_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ssb_pkg::div_req_type div_req,
   output ssb_pkg::div_rsp_type div_rsp
);
   import ssb_pkg::*;

   localparam int TRIAL_W = IDX_W + 1;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [HSTEP_W-1:0] step_ff, step_in;
   logic [HASH_W-1:0]  shift_ff, shift_in;
   logic [IDX_W-1:0]   rem_ff, rem_in;
   logic [TRIAL_W-1:0] div_ff, div_in;
   logic [TRIAL_W-1:0] trial;
   logic [TRIAL_W-1:0] diff;

   // One quotient bit per cycle, MSB first; only the remainder is kept
   always_comb begin
      trial    = {rem_ff, shift_ff[HASH_W-1]};
      diff     = trial - div_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = div_req.dividend;
         rem_in   = '0;
         div_in   = TRIAL_W'(div_req.divisor);
      end else if (busy_ff) begin
         shift_in = {shift_ff[HASH_W-2:0], 1'b0};
         rem_in   = (trial >= div_ff) ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
         step_in  = step_ff + 1'b1;
         if (step_ff == HSTEP_W'(HASH_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== rtl/ssb_engine.sv =====
module ssb_engine (
   input  logic             clock,
   input  logic             reset,
   input  ssb_pkg::cfg_type cfg,
   input  logic             req_valid,
   input  ssb_pkg::req_type req_data,
   output logic             idle,
   output logic             res_valid,
   output ssb_pkg::rsp_type res_data,
   input  logic             res_ready
);
   import ssb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HASH,
      ST_READ,
      ST_UPDATE,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   req_type                item_ff, item_in;
   rsp_type                res_ff, res_in;
   logic [IDX_W-1:0]       pick_ff, pick_in;
   logic [IDX_W-1:0]       rr_ff, rr_in;
   logic [MAX_SERVERS-1:0] alive_ff, alive_in;
   logic [MAX_SERVERS-1:0] cnt_vld_ff, cnt_vld_in;
   logic [POOL_W-1:0]      issue_ff, issue_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [COUNT_WIDTH-1:0] min_val_ff, min_val_in;
   logic [IDX_W-1:0]       min_idx_ff, min_idx_in;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [COUNT_WIDTH-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [COUNT_WIDTH-1:0] ram_rd_data;

   div_req_type            div_req;
   div_rsp_type            div_rsp;

   logic [IDX_W-1:0]       look_idx;
   logic [COUNT_WIDTH-1:0] cur_val;
   logic [IDX_W-1:0]       rr_pick;
   logic [POOL_W-1:0]      rr_next;

   ssb_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_SERVERS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ssb_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // A counter never written since reset reads as zero
   assign look_idx = (state_ff == ST_SCAN) ? cmp_idx_ff : pick_ff;
   assign cur_val  = cnt_vld_ff[look_idx] ? ram_rd_data : '0;

   // Round robin pick with stale pointer folded to zero
   assign rr_pick = (POOL_W'(rr_ff) < cfg.count) ? rr_ff : '0;
   assign rr_next = POOL_W'(rr_pick) + 1'b1;

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      res_in      = res_ff;
      pick_in     = pick_ff;
      rr_in       = rr_ff;
      alive_in    = alive_ff;
      cnt_vld_in  = cnt_vld_ff;
      issue_in    = issue_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      min_val_in  = min_val_ff;
      min_idx_in  = min_idx_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pick_ff;
      ram_wr_data = cur_val;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pick_ff;
      div_req.start    = 1'b0;
      div_req.dividend = req_data.client_hash;
      div_req.divisor  = cfg.count;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               case (req_data.kind)
                  KIND_REQUEST: begin
                     if (cfg.count == '0) begin
                        res_in   = '{chosen_server: '0, status: STATUS_NO_SERVERS};
                        state_in = ST_DONE;
                     end else begin
                        case (cfg.mode)
                           MODE_RR: begin
                              pick_in  = rr_pick;
                              rr_in    = (rr_next == cfg.count) ? '0 : rr_next[IDX_W-1:0];
                              state_in = ST_READ;
                           end
                           MODE_LC: begin
                              issue_in   = '0;
                              cmp_vld_in = 1'b0;
                              state_in   = ST_SCAN;
                           end
                           MODE_HASH: begin
                              div_req.start = 1'b1;
                              state_in      = ST_HASH;
                           end
                           default: begin
                              res_in   = '{chosen_server: '0, status: STATUS_NO_SERVERS};
                              state_in = ST_DONE;
                           end
                        endcase
                     end
                  end
                  KIND_RELEASE, KIND_HEALTH: begin
                     if (POOL_W'(req_data.server_index) >= cfg.count) begin
                        res_in   = '{chosen_server: req_data.server_index,
                                     status: STATUS_NO_SERVERS};
                        state_in = ST_DONE;
                     end else if (req_data.kind == KIND_RELEASE) begin
                        pick_in  = req_data.server_index;
                        state_in = ST_READ;
                     end else begin
                        alive_in[req_data.server_index] = req_data.alive_flag;
                        res_in   = '{chosen_server: req_data.server_index,
                                     status: STATUS_ACK};
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     res_in   = '{chosen_server: req_data.server_index, status: STATUS_ACK};
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue one read per cycle, compare the data in the cycle after
            if (issue_ff < cfg.count) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = issue_ff[IDX_W-1:0];
            end else begin
               cmp_vld_in = 1'b0;
            end
            if (cmp_vld_ff) begin
               if (cmp_idx_ff == '0 || cur_val < min_val_ff) begin
                  min_val_in = cur_val;
                  min_idx_in = cmp_idx_ff;
               end
            end else if (issue_ff == cfg.count) begin
               pick_in  = min_idx_ff;
               state_in = ST_READ;
            end
         end

         ST_HASH: begin
            if (div_rsp.done) begin
               pick_in  = div_rsp.remainder;
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_UPDATE;
         end

         ST_UPDATE: begin
            if (item_ff.kind == KIND_REQUEST) begin
               if (!alive_ff[pick_ff]) begin
                  res_in = '{chosen_server: pick_ff, status: STATUS_DEAD};
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = (cur_val == '1) ? cur_val : cur_val + 1'b1;
                  cnt_vld_in[pick_ff] = 1'b1;
                  res_in = '{chosen_server: pick_ff, status: STATUS_FORWARDED};
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = (cur_val == '0) ? cur_val : cur_val - 1'b1;
               cnt_vld_in[pick_ff] = 1'b1;
               res_in = '{chosen_server: pick_ff, status: STATUS_ACK};
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rr_ff      <= '0;
         alive_ff   <= '1;
         cnt_vld_ff <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rr_ff      <= rr_in;
         alive_ff   <= alive_in;
         cnt_vld_ff <= cnt_vld_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      item_ff    <= item_in;
      res_ff     <= res_in;
      pick_ff    <= pick_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      min_val_ff <= min_val_in;
      min_idx_ff <= min_idx_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;

endmodule

// ===== rtl/server_selection_balancer.sv =====
// Server selection balancer: takes one beat per item (request, release or
// health report) and returns exactly one result beat per item. Requests pick a
// server by round robin, least open connections (first minimum, liveness
// ignored) or client hash modulo the pool size; a live pick has its open count
// raised, saturating. Releases lower a count, floored at zero; health reports
// set a server's alive bit. The open counts live in a one-port-read, one-port-
// write RAM with registered read; alive bits, the round robin pointer and the
// per-entry written bits are flops, so no clearing pass follows reset. One item
// is in flight at a time. Least connections reads one counter per cycle through
// the RAM port; hash mode produces one remainder bit per cycle over the 32-bit
// hash. The result register frees the engine, so a new item is taken as soon
// as the previous result is loaded, even if it is stalled.
module server_selection_balancer (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  ssb_pkg::req_type             req_data,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ssb_pkg::rsp_type             rsp_data,

   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ssb_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [ssb_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ssb_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import ssb_pkg::*;

   // Register select bit of the byte address (registers sit 4 bytes apart)
   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_COUNT = 1'b1;

   logic [1:0]          mode_ff, mode_in;
   logic [SCOUNT_W-1:0] count_ff, count_in;
   logic                csr_wr;
   cfg_type             cfg;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                eng_idle;
   logic                eng_res_valid;
   rsp_type             eng_res_data;
   logic                eng_res_ready;

   // Configuration writes complete in the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_MODE:  mode_in  = csr_pwdata[1:0];
            REG_COUNT: count_in = csr_pwdata[SCOUNT_W-1:0];
            default:   mode_in  = mode_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_MODE:  csr_prdata = CSR_DW'(mode_ff);
         REG_COUNT: csr_prdata = CSR_DW'(count_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // Saturate the pool size to the number of counters
   assign cfg.mode  = mode_ff;
   assign cfg.count = (count_ff > SCOUNT_W'(MAX_SERVERS)) ? POOL_W'(MAX_SERVERS)
                                                          : POOL_W'(count_ff);

   ssb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_data  (req_data),
      .idle      (eng_idle),
      .res_valid (eng_res_valid),
      .res_data  (eng_res_data),
      .res_ready (eng_res_ready)
   );

   // Hold new items while the engine works on one
   assign req_stall = ~eng_idle;

   // Result register: load when empty or draining this cycle
   assign eng_res_ready = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_res_valid && eng_res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted beat leaves the engine busy in the cycle after acceptance
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine idle right after accepting a beat");

   // A fresh result beat only comes from an item that was in progress
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat without an item in progress");

endmodule
